/* rtl/lppe_pkg.sv */
// Package with the types, constants and register codes of the LED pixel pulse encoder.
`default_nettype none
package lppe_pkg;

    localparam int DURATION_BITS = 15;
    localparam int FIELD_W       = 15;
    localparam int CFG_IDX_W     = 3;
    localparam int WORDS         = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_LOW  = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [FIELD_W-1:0] high_time;
        logic [FIELD_W-1:0] low_time;
        logic               pixel_done;
        logic               frame_end;
    } t_word;

    typedef struct packed {
        logic valid;
        logic bit_val;
        logic final_bit;
        logic frame_end;
    } t_cell;

    typedef struct packed {
        logic [DURATION_BITS-1:0] zero_high;
        logic [DURATION_BITS-1:0] zero_low;
        logic [DURATION_BITS-1:0] one_high;
        logic [DURATION_BITS-1:0] one_low;
        logic [DURATION_BITS-1:0] latch_low;
    } t_timing;

endpackage
`default_nettype wire

/* rtl/led_pixel_pulse_encoder_unit.sv */
// Top level of the LED pixel pulse encoder: bit chain, timing registers, output word register.
//
// Channel   Direction  Handshake            Word
// pixel     in         i_valid / o_ready    i_data  (t_pixel)
// pulse     out        o_valid / i_ready    o_data  (t_word)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A pixel loads 24 cells at once and one word leaves the chain head per cycle
// while the output is not stalled. A new pixel is taken in the cycle its
// predecessor's last bit leaves the head; its first word passes through the head
// cell and the output register. Output stalls hold the chain and the output register.
// Reset is synchronous and empties the chain and the output register.
`default_nettype none
module led_pixel_pulse_encoder_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  lppe_pkg::t_pixel                   i_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output lppe_pkg::t_word                    o_data,
    input  wire                                i_cfg_we,
    input  wire [lppe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [lppe_pkg::FIELD_W-1:0]        i_cfg_data
);

    lppe_pkg::t_timing timing;
    lppe_pkg::t_cell   cells [lppe_pkg::WORDS];
    lppe_pkg::t_cell   load_cells [lppe_pkg::WORDS];
    lppe_pkg::t_cell   next_cells [lppe_pkg::WORDS];
    logic [lppe_pkg::WORDS-1:0] stream;
    logic              shift;
    logic              load;
    logic              r_out_valid;
    lppe_pkg::t_word   r_out;
    lppe_pkg::t_word   n_out;
    logic [lppe_pkg::DURATION_BITS-1:0] hi_sel;
    logic [lppe_pkg::DURATION_BITS-1:0] lo_sel;

    lppe_timing u_timing (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_timing   (timing)
    );

    assign stream  = {i_data.green, i_data.red, i_data.blue};
    assign shift   = cells[0].valid && (!r_out_valid || i_ready);
    assign o_ready = !cells[1].valid && (!cells[0].valid || shift);
    assign load    = i_valid && o_ready;

    for (genvar k = 0; k < lppe_pkg::WORDS; k++) begin : g_chain
        always_comb begin
            load_cells[k].valid     = 1'b1;
            load_cells[k].bit_val   = stream[lppe_pkg::WORDS-1-k];
            load_cells[k].final_bit = (k == lppe_pkg::WORDS - 1);
            load_cells[k].frame_end = (k == lppe_pkg::WORDS - 1) && i_data.last_pixel;
        end
        if (k == lppe_pkg::WORDS - 1) begin : g_tail
            assign next_cells[k] = '0;
        end else begin : g_body
            assign next_cells[k] = cells[k+1];
        end
        lppe_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (load),
            .i_shift     (shift),
            .i_load_cell (load_cells[k]),
            .i_next_cell (next_cells[k]),
            .o_cell      (cells[k])
        );
    end

    always_comb begin
        hi_sel = cells[0].bit_val ? timing.one_high : timing.zero_high;
        lo_sel = cells[0].bit_val ? timing.one_low  : timing.zero_low;
        if (cells[0].frame_end) begin
            lo_sel = timing.latch_low;
        end
        n_out.high_time  = lppe_pkg::FIELD_W'(hi_sel);
        n_out.low_time   = lppe_pkg::FIELD_W'(lo_sel);
        n_out.pixel_done = cells[0].final_bit;
        n_out.frame_end  = cells[0].frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (shift) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* rtl/lppe_cell.sv */
// One cell of the bit chain: holds one pending bit and passes it toward the head.
`default_nettype none
module lppe_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  wire              i_shift,
    input  lppe_pkg::t_cell  i_load_cell,
    input  lppe_pkg::t_cell  i_next_cell,
    output lppe_pkg::t_cell  o_cell
);

    lppe_pkg::t_cell r_cell;
    lppe_pkg::t_cell n_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_load) begin
            n_cell = i_load_cell;
        end else if (i_shift) begin
            n_cell = i_next_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.bit_val   <= n_cell.bit_val;
        r_cell.final_bit <= n_cell.final_bit;
        r_cell.frame_end <= n_cell.frame_end;
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

/* rtl/lppe_timing.sv */
// Timing registers of the pulse encoder, written through the configuration port.
`default_nettype none
module lppe_timing (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [lppe_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [lppe_pkg::FIELD_W-1:0]          i_cfg_data,
    output lppe_pkg::t_timing                    o_timing
);

    lppe_pkg::t_timing r_timing;
    lppe_pkg::t_timing n_timing;
    logic [lppe_pkg::DURATION_BITS-1:0] n_value;

    always_comb begin
        n_value  = lppe_pkg::DURATION_BITS'(i_cfg_data);
        n_timing = r_timing;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                lppe_pkg::REG_ZERO_HIGH: n_timing.zero_high = n_value;
                lppe_pkg::REG_ZERO_LOW:  n_timing.zero_low  = n_value;
                lppe_pkg::REG_ONE_HIGH:  n_timing.one_high  = n_value;
                lppe_pkg::REG_ONE_LOW:   n_timing.one_low   = n_value;
                lppe_pkg::REG_LATCH_LOW: n_timing.latch_low = n_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.zero_high <= lppe_pkg::DURATION_BITS'(7);
            r_timing.zero_low  <= lppe_pkg::DURATION_BITS'(18);
            r_timing.one_high  <= lppe_pkg::DURATION_BITS'(18);
            r_timing.one_low   <= lppe_pkg::DURATION_BITS'(7);
            r_timing.latch_low <= lppe_pkg::DURATION_BITS'(1000);
        end else begin
            r_timing <= n_timing;
        end
    end

    assign o_timing = r_timing;

endmodule
`default_nettype wire

/* rtl/lppe_checker.sv */
// Port-level assertions for the LED pixel pulse encoder and their bind to the top level.
`default_nettype none
module lppe_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  wire                                o_ready,
    input  wire                                o_valid,
    input  wire                                i_ready,
    input  lppe_pkg::t_word                    o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("Output word changed or dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Ready stayed high right after a pixel was taken.");

    a_frame_on_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_end |-> o_data.pixel_done)
        else $error("Frame end flagged on a word that does not end a pixel.");

    a_words_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.pixel_done |=> o_valid)
        else $error("Gap between words of one pixel.");

endmodule

bind led_pixel_pulse_encoder_unit lppe_checker u_lppe_checker (.*);
`default_nettype wire
